>>> rtl/box_mean_filter_2d_defines.svh
// assertion macros for the box mean filter
// used by box_mean_filter_2d.sv, expects clk and rst_n in scope
`ifndef BOX_MEAN_FILTER_2D_DEFINES_SVH
`define BOX_MEAN_FILTER_2D_DEFINES_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box filter check failed");

// next-cycle implication
`define BMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box filter check failed");

`endif

>>> rtl/bmf_pkg.sv
// shared types and constants for the box mean filter
// no dependencies
`default_nettype none

package bmf_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_K_W    = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_HEIGHT = 4096;
    localparam int POS_W      = 24;
    localparam int SUM_W      = 14;
    localparam int DIV_W      = 6;
    localparam int REM_W      = 7;
    localparam int DCNT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd2;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } bmf_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last_of_frame;
    } bmf_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_READ,
        S_FLUSH,
        S_DLOAD,
        S_DIV,
        S_OUT
    } bmf_state_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic read;
        logic dload;
        logic div_step;
        logic emit;
    } bmf_cmd_t;

    typedef struct packed {
        logic has_result;
        logic read_last;
        logic div_last;
        logic out_free;
    } bmf_status_t;

endpackage

`default_nettype wire

>>> rtl/bmf_datapath.sv
// datapath: config registers, row store, window accumulation, divider, output register
// depends on bmf_pkg
`default_nettype none

module bmf_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bmf_pkg::bmf_cmd_t               cmd,
    output bmf_pkg::bmf_status_t                 status,
    input  wire bmf_pkg::bmf_in_t                in_data,
    input  wire logic                            cfg_we,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output bmf_pkg::bmf_out_t                    out_data
);
    import bmf_pkg::*;

    localparam int RAD_MAX = MAX_KERNEL / 2;
    localparam int DEPTH   = 2 * RAD_MAX * MAX_WIDTH + 2 * RAD_MAX + 1;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W_W-1:0] cfg_w_reg;
    logic [CFG_H_W-1:0] cfg_h_reg;
    logic [CFG_K_W-1:0] cfg_k_reg;

    logic [PIX_W-1:0] mem [DEPTH];

    logic [POS_W-1:0]   in_pos_reg;
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      cur_ptr_reg;
    logic [CFG_W_W-1:0] out_col_reg;
    logic [CFG_H_W-1:0] out_row_reg;

    logic [AW-1:0]      row_base_reg;
    logic [AW-1:0]      col_addr_reg;
    logic signed [CFG_H_W:0] rr_reg;
    logic signed [CFG_W_W:0] cc_reg;
    logic [2:0]         dr_reg;
    logic [2:0]         dc_reg;

    logic [PIX_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_in_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [SUM_W-1:0]   quo_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;

    logic               out_valid_reg;
    bmf_out_t           out_data_reg;

    // effective settings
    logic [CFG_W_W-1:0] w_eff;
    logic [CFG_H_W-1:0] h_eff;
    logic [CFG_K_W-1:0] k_eff;
    logic [1:0]         rad;
    logic [2:0]         side_m1;
    logic [DIV_W-1:0]   divisor;
    logic [POS_W-1:0]   lag;
    logic [AW-1:0]      lag2;
    logic [POS_W-1:0]   total;

    logic [AW:0]        base_diff;
    logic [AW-1:0]      base_ptr;
    logic [AW:0]        rb_sum;
    logic [AW-1:0]      rb_next;
    logic [AW-1:0]      col_next;
    logic               in_bounds;
    logic               last_pix;
    logic [REM_W-1:0]   trial;
    logic               cfg_hit;

    always_comb
    begin
        if (cfg_w_reg == '0)
            w_eff = CFG_W_W'(1);
        else if (32'(cfg_w_reg) > MAX_WIDTH)
            w_eff = CFG_W_W'(MAX_WIDTH);
        else
            w_eff = cfg_w_reg;

        if (cfg_h_reg == '0)
            h_eff = CFG_H_W'(1);
        else if (32'(cfg_h_reg) > MAX_HEIGHT)
            h_eff = CFG_H_W'(MAX_HEIGHT);
        else
            h_eff = cfg_h_reg;

        if (cfg_k_reg == '0)
            k_eff = CFG_K_W'(1);
        else if (32'(cfg_k_reg) > MAX_KERNEL)
            k_eff = CFG_K_W'(MAX_KERNEL);
        else
            k_eff = cfg_k_reg;

        rad     = k_eff[2:1];
        side_m1 = {rad, 1'b0};
        divisor = DIV_W'(k_eff * k_eff);
        lag     = POS_W'(rad * w_eff) + POS_W'(rad);
        lag2    = AW'({lag, 1'b0});
        total   = POS_W'(w_eff * h_eff);
    end

    // window start sits 2*lag positions behind the newest pixel, circularly
    always_comb
    begin
        base_diff = (AW+1)'(cur_ptr_reg) - (AW+1)'(lag2);
        if (base_diff[AW])
            base_ptr = AW'(base_diff + (AW+1)'(DEPTH));
        else
            base_ptr = base_diff[AW-1:0];

        rb_sum = (AW+1)'(row_base_reg) + (AW+1)'(w_eff);
        if (rb_sum >= (AW+1)'(DEPTH))
            rb_next = AW'(rb_sum - (AW+1)'(DEPTH));
        else
            rb_next = rb_sum[AW-1:0];

        if (col_addr_reg == AW'(DEPTH - 1))
            col_next = '0;
        else
            col_next = col_addr_reg + AW'(1);

        in_bounds = (rr_reg >= 0) && (rr_reg < $signed({1'b0, h_eff}))
                 && (cc_reg >= 0) && (cc_reg < $signed({1'b0, w_eff}));

        last_pix = (out_row_reg == h_eff - CFG_H_W'(1))
                && (out_col_reg == w_eff - CFG_W_W'(1));

        trial = {rem_reg[REM_W-2:0], quo_reg[SUM_W-1]};

        cfg_hit = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                          || cfg_index == REG_KERNEL);
    end

    assign status.has_result = (in_pos_reg >= lag);
    assign status.read_last  = (dr_reg == side_m1) && (dc_reg == side_m1);
    assign status.div_last   = (div_cnt_reg == DCNT_W'(SUM_W - 1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // row store, undefined until written
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_pos_reg < total)
            mem[wr_ptr_reg] <= in_data.op ? '0 : in_data.pixel;
        if (cmd.read)
            rd_data_reg <= mem[col_addr_reg];
    end

    // config registers and stream positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg   <= CFG_W_W'(1024);
            cfg_h_reg   <= CFG_H_W'(1024);
            cfg_k_reg   <= CFG_K_W'(3);
            in_pos_reg  <= '0;
            wr_ptr_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (cfg_index)
                REG_WIDTH:  cfg_w_reg <= cfg_data[CFG_W_W-1:0];
                REG_HEIGHT: cfg_h_reg <= cfg_data[CFG_H_W-1:0];
                default:    cfg_k_reg <= cfg_data[CFG_K_W-1:0];
            endcase
            in_pos_reg  <= '0;
            wr_ptr_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                in_pos_reg <= in_pos_reg + POS_W'(1);
                if (wr_ptr_reg == AW'(DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                if (last_pix)
                begin
                    in_pos_reg  <= '0;
                    wr_ptr_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else if (out_col_reg == w_eff - CFG_W_W'(1))
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + CFG_H_W'(1);
                end
                else
                    out_col_reg <= out_col_reg + CFG_W_W'(1);
            end
        end
    end

    // window walk, accumulation and divider
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            cur_ptr_reg <= wr_ptr_reg;

        if (cmd.init)
        begin
            row_base_reg <= base_ptr;
            col_addr_reg <= base_ptr;
            rr_reg       <= $signed({1'b0, out_row_reg}) - (CFG_H_W+1)'(rad);
            cc_reg       <= $signed({1'b0, out_col_reg}) - (CFG_W_W+1)'(rad);
            dr_reg       <= '0;
            dc_reg       <= '0;
            sum_reg      <= '0;
        end
        else if (cmd.read)
        begin
            if (dc_reg == side_m1)
            begin
                dc_reg       <= '0;
                dr_reg       <= dr_reg + 3'd1;
                rr_reg       <= rr_reg + (CFG_H_W+1)'(1);
                cc_reg       <= $signed({1'b0, out_col_reg}) - (CFG_W_W+1)'(rad);
                row_base_reg <= rb_next;
                col_addr_reg <= rb_next;
            end
            else
            begin
                dc_reg       <= dc_reg + 3'd1;
                cc_reg       <= cc_reg + (CFG_W_W+1)'(1);
                col_addr_reg <= col_next;
            end
        end

        // read data is registered, so it is added in the cycle after its address
        if (rd_valid_reg && rd_in_reg && !cmd.init)
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);

        if (cmd.dload)
        begin
            quo_reg     <= sum_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
            if (trial >= REM_W'(divisor))
            begin
                rem_reg <= trial - REM_W'(divisor);
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end

        if (cmd.emit)
        begin
            out_data_reg.value         <= (quo_reg > SUM_W'(255)) ? '1 : quo_reg[PIX_W-1:0];
            out_data_reg.last_of_frame <= last_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            rd_in_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.read;
            rd_in_reg    <= in_bounds;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bmf_ctrl.sv
// controller state machine sequencing one pixel transaction at a time
// depends on bmf_pkg
`default_nettype none

module bmf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire bmf_pkg::bmf_status_t status,
    output bmf_pkg::bmf_cmd_t         cmd
);
    import bmf_pkg::*;

    bmf_state_t state_reg;
    bmf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && status.has_result)
                    state_next = S_INIT;
            S_INIT:
                state_next = S_READ;
            S_READ:
                if (status.read_last)
                    state_next = S_FLUSH;
            S_FLUSH:
                state_next = S_DLOAD;
            S_DLOAD:
                state_next = S_DIV;
            S_DIV:
                if (status.div_last)
                    state_next = S_OUT;
            S_OUT:
                if (status.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_INIT:  cmd.init     = 1'b1;
            S_READ:  cmd.read     = 1'b1;
            S_FLUSH: ;
            S_DLOAD: cmd.dload    = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_OUT:   cmd.emit     = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/box_mean_filter_2d.sv
// top level of the box mean filter: controller plus datapath
// depends on bmf_pkg, bmf_ctrl, bmf_datapath and box_mean_filter_2d_defines.svh
`default_nettype none
`include "box_mean_filter_2d_defines.svh"

// Streaming box (mean) filter over an 8-bit raster image. A transaction whose
// position is still inside the output lag (kernel_size/2 rows plus as many
// pixels) is accepted, gives no result and leaves the block ready. Any other
// transaction reads a side*side window, side = 2*(kernel_size/2)+1: the row
// store has one port, so the window is read one pixel a cycle, and the mean comes
// from a 14-step shift-subtract divider. The result sits in an output register
// while the next pixel is taken. The row store holds 2*(MAX_KERNEL/2)*MAX_WIDTH
// + 2*(MAX_KERNEL/2) + 1 pixels, needs no clearing after reset, and is used
// circularly. Configuration writes are always taken; writes to the width, height
// and kernel registers restart the frame; write them only while the block is idle.
module box_mean_filter_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire bmf_pkg::bmf_in_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output bmf_pkg::bmf_out_t                    out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bmf_pkg::*;

    bmf_cmd_t    cmd;
    bmf_status_t status;

    assign cfg_ready = 1'b1;

    bmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a transaction inside the lag leaves the block ready
    `BMF_ASSERT_NEXT(a_lag_item_no_stall, in_valid && !in_stall && !status.has_result, !in_stall)
    // a transaction with a result holds off the next one
    `BMF_ASSERT_NEXT(a_result_item_stalls, in_valid && !in_stall && status.has_result, in_stall)
    // at most one datapath step at a time
    `BMF_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.accept, cmd.init, cmd.read, cmd.dload, cmd.div_step, cmd.emit}))

endmodule

`default_nettype wire

>>> sim/tb_box_mean_filter_2d.sv
// self-checking testbench for the box mean filter top level
// depends on bmf_pkg and box_mean_filter_2d; pixels and drain ticks are checked
// against a behavioral filter model kept inside this module
`default_nettype none

module tb_box_mean_filter_2d;
    import bmf_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_K      = 7;
    localparam int HIST_DEPTH = 2 * (MAX_K / 2) * MAX_W + 2 * (MAX_K / 2) + 1;
    localparam int QUIET      = 120;
    localparam int RAND_ITEMS = 1250;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bmf_in_t               item;
    } stim_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    bmf_in_t in_data;
    logic out_valid;
    logic out_stall;
    bmf_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    box_mean_filter_2d dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    stim_t    pending[$];
    bmf_out_t expected_pix[$];

    // filter model state
    logic [7:0]  pix_hist [0:HIST_DEPTH-1];
    int unsigned col_in, row_in, col_out, row_out;
    int unsigned img_w, img_h, ksize;

    int  errors = 0;
    int  n_results = 0;
    int  n_frames = 0;
    int  n_items = 0;
    int  quiet_cnt = 0;
    int  cyc = 0;
    int  in_gap = 0;
    int  stall_left = 0;
    bit  calm;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        if (idx == REG_WIDTH) img_w = d & 13'h7FF;
        else if (idx == REG_HEIGHT) img_h = d & 13'h1FFF;
        else if (idx == REG_KERNEL) ksize = d & 13'h7;
        else return;
        col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    endfunction

    function automatic void model_pixel(bmf_in_t it);
        int unsigned w, h, k, r, side, lag, total, p, sum, res, q;
        bmf_out_t e;
        w = img_w; h = img_h; k = ksize;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (k == 0) k = 1;
        if (k > MAX_K) k = MAX_K;
        r = k / 2;
        side = 2 * r + 1;
        lag = r * w + r;
        total = w * h;
        p = row_in * w + col_in;
        if (p < total) pix_hist[p % HIST_DEPTH] = (it.op == OP_DRAIN) ? 8'd0 : it.pixel;
        col_in++;
        if (col_in >= w)
        begin
            col_in = 0;
            row_in++;
        end
        if (p < lag) return;
        sum = 0;
        for (int unsigned dr = 0; dr < side; dr++)
            for (int unsigned dc = 0; dc < side; dc++)
                if (row_out + dr >= r && row_out + dr - r < h &&
                    col_out + dc >= r && col_out + dc - r < w)
                begin
                    q = (row_out + dr - r) * w + (col_out + dc - r);
                    sum += pix_hist[q % HIST_DEPTH];
                end
        res = sum / (k * k);
        if (res > 255) res = 255;
        e.value = res[7:0];
        e.last_of_frame = (row_out == h - 1 && col_out == w - 1);
        expected_pix.push_back(e);
        if (e.last_of_frame)
        begin
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        end
        else
        begin
            col_out++;
            if (col_out >= w)
            begin
                col_out = 0;
                row_out++;
            end
        end
    endfunction

    // driver: pixel and config transactions from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                model_pixel(in_data);
                void'(pending.pop_front());
                in_gap = pick_gap();
            end
            if (cfg_valid && cfg_ready)
            begin
                model_config(cfg_index, cfg_data);
                void'(pending.pop_front());
            end
            if ((in_valid && in_stall) || (cfg_valid && !cfg_ready))
            begin
                // hold the stalled transaction
            end
            else if (in_gap > 0)
            begin
                in_gap--;
                in_valid  <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else if (pending.size() == 0)
            begin
                in_valid  <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else if (pending[0].is_cfg)
            begin
                in_valid <= 1'b0;
                // registers change only once the filter has gone quiet
                if (expected_pix.size() == 0 && quiet_cnt >= QUIET)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= pending[0].idx;
                    cfg_data  <= pending[0].data;
                end
                else
                    cfg_valid <= 1'b0;
            end
            else
            begin
                cfg_valid <= 1'b0;
                in_valid  <= 1'b1;
                in_data   <= pending[0].item;
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        bmf_out_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            cyc++;
            calm = ((cyc / 4000) % 4) == 3;
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_pix.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result value=%0d last=%0b", $time,
                             out_data.value, out_data.last_of_frame);
                end
                else
                begin
                    e = expected_pix.pop_front();
                    if (e.value !== out_data.value)
                    begin
                        errors++;
                        $display("%0t: value expected %0d actual %0d", $time,
                                 e.value, out_data.value);
                    end
                    if (e.last_of_frame !== out_data.last_of_frame)
                    begin
                        errors++;
                        $display("%0t: last_of_frame expected %0b actual %0b", $time,
                                 e.last_of_frame, out_data.last_of_frame);
                    end
                end
            end
            if ((out_valid && !out_stall) || expected_pix.size() != 0) quiet_cnt = 0;
            else if (quiet_cnt < QUIET) quiet_cnt++;
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, int d);
        stim_t s;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = d[CFG_DATA_W-1:0];
        s.item = '0;
        pending.push_back(s);
    endfunction

    function automatic void push_item(logic op, int pix);
        stim_t s;
        s.is_cfg = 1'b0;
        s.idx = '0;
        s.data = '0;
        s.item.op = op;
        s.item.pixel = pix[7:0];
        pending.push_back(s);
        n_items++;
    endfunction

    function automatic int rand_pixel(int style);
        int r;
        r = $urandom_range(0, 9);
        if (style == 1) return 255;
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(0, 255);
    endfunction

    // one frame: set all registers, send pixels, then drain ticks up to the last result
    // noise: 1 drain ticks inside the frame, 2 pixels among the drains, 3 abort early
    function automatic void push_frame(int w, int h, int k, int style, int noise);
        int ew, eh, ek, total, lag, n;
        // registers keep only their low bits
        ew = w & 'h7FF;
        eh = h & 'h1FFF;
        ek = k & 'h7;
        ew = (ew == 0) ? 1 : (ew > MAX_W ? MAX_W : ew);
        eh = (eh == 0) ? 1 : (eh > MAX_HEIGHT ? MAX_HEIGHT : eh);
        ek = (ek == 0) ? 1 : (ek > MAX_K ? MAX_K : ek);
        total = ew * eh;
        lag = (ek / 2) * ew + ek / 2;
        push_cfg(REG_WIDTH, w);
        push_cfg(REG_HEIGHT, h);
        push_cfg(REG_KERNEL, k);
        n_frames++;
        n = (noise == 3) ? $urandom_range(0, total + lag - 1) : total + lag;
        for (int i = 0; i < n; i++)
        begin
            if (i < total)
            begin
                if (noise == 1 && $urandom_range(0, 4) == 0)
                    push_item(OP_DRAIN, $urandom_range(0, 255));
                else
                    push_item(OP_PIXEL, rand_pixel(style));
            end
            else if (noise == 2 && $urandom_range(0, 1) == 0)
                push_item(OP_PIXEL, $urandom_range(0, 255));
            else
                push_item(OP_DRAIN, $urandom_range(0, 255));
        end
    endfunction

    initial
    begin
        int wait_cnt;
        img_w = 1024; img_h = 1024; ksize = 3;
        col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        for (int i = 0; i < HIST_DEPTH; i++) pix_hist[i] = 8'd0;

        // directed: kernels, saturation on even sizes, odd register values
        push_frame(1, 1, 1, 0, 0);
        push_frame(3, 2, 3, 0, 1);
        push_frame(2, 2, 2, 1, 0);
        push_frame(3, 3, 4, 1, 0);
        push_frame(3, 2, 6, 1, 2);
        push_frame(4, 3, 7, 0, 0);
        push_frame(0, 0, 0, 0, 0);
        push_cfg(REG_NONE, 8191);
        push_item(OP_PIXEL, 255);
        push_item(OP_DRAIN, 0);
        push_frame(3, 3, 5, 0, 3);
        // width and kernel values whose low bits are zero
        push_frame(2048, 3, 8, 0, 0);

        // random frames, mostly well formed, small sizes
        begin
            int start;
            int w, h, k, nz;
            start = n_items;
            while (n_items - start < RAND_ITEMS)
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                k = $urandom_range(0, 7);
                if ($urandom_range(0, 19) == 0)
                begin
                    w = $urandom_range(13, 40);
                    h = $urandom_range(1, 3);
                end
                nz = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
                push_frame(w, h, k, ($urandom_range(0, 9) == 0) ? 1 : 0, nz);
            end
        end

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || expected_pix.size() != 0) @(posedge clk);
        wait_cnt = 0;
        while (wait_cnt < 200)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (expected_pix.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_pix.size());
        end
        $display("ran %0d frames, %0d input transactions, %0d results checked",
                 n_frames, n_items, n_results);
        if (errors == 0)
            $display("tb_box_mean_filter_2d OK");
        else
            $display("tb_box_mean_filter_2d NOT OK");
        $finish;
    end

    initial
    begin
        #24000000;
        $display("%0t: timeout, %0d transactions and %0d results outstanding", $time,
                 pending.size(), expected_pix.size());
        $display("tb_box_mean_filter_2d NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_datapath.sv
rtl/bmf_ctrl.sv
rtl/box_mean_filter_2d.sv
sim/tb_box_mean_filter_2d.sv
